>>> src/utt_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to ASCII transliterator package
// Shared types, byte codes and the transliteration table.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int CHAR_W           = 7;
    localparam int BYTE_W           = 8;
    localparam int CFG_W            = 13;
    localparam int MAX_CHARS        = 4;
    localparam int CNT_W            = 3;
    localparam int CAPACITY_MAX_DEF = 4096;
    localparam logic [CFG_W-1:0] CAP_RESET = 13'd512;

    localparam logic [BYTE_W-1:0] LEAD_C2 = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_C3 = 8'hC3;
    localparam logic [BYTE_W-1:0] LEAD_C5 = 8'hC5;
    localparam logic [BYTE_W-1:0] LEAD_E2 = 8'hE2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 7'h3F;

    typedef struct packed {
        logic [CNT_W-1:0]                    len;
        logic [MAX_CHARS-1:0][CHAR_W-1:0]    ch;
    } t_str;

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0]    ch;
        logic [CNT_W-1:0]                    cnt;
        logic                                last;
    } t_res;

    // The text is left-justified in s, first character in the top byte.
    function automatic t_str mk(input logic [CNT_W-1:0] len, input logic [31:0] s);
        t_str r;
        r.len = len;
        for (int i = 0; i < MAX_CHARS; i++) begin
            r.ch[i] = s[8*(3-i) +: CHAR_W];
        end
        return r;
    endfunction

    function automatic t_str lookup(input logic [BYTE_W-1:0] lead,
                                    input logic [BYTE_W-1:0] mid,
                                    input logic [BYTE_W-1:0] last);
        t_str r;
        r = mk(3'd1, "?   ");
        if (lead == LEAD_C2) begin
            case (mid)
                8'hA0: r = mk(3'd1, "    ");
                8'hB0: r = mk(3'd4, " deg");
                8'hB1: r = mk(3'd3, "+/- ");
                8'hB7: r = mk(3'd1, "-   ");
                default: r = mk(3'd1, "?   ");
            endcase
        end else if (lead == LEAD_C3) begin
            case (mid) inside
                [8'h80:8'h85]: r = mk(3'd1, "A   ");
                8'h86:         r = mk(3'd2, "AE  ");
                8'h87:         r = mk(3'd1, "C   ");
                [8'h88:8'h8B]: r = mk(3'd1, "E   ");
                [8'h8C:8'h8F]: r = mk(3'd1, "I   ");
                8'h91:         r = mk(3'd1, "N   ");
                [8'h92:8'h96], 8'h98: r = mk(3'd1, "O   ");
                [8'h99:8'h9C]: r = mk(3'd1, "U   ");
                8'h9D:         r = mk(3'd1, "Y   ");
                8'h9F:         r = mk(3'd2, "ss  ");
                [8'hA0:8'hA5]: r = mk(3'd1, "a   ");
                8'hA6:         r = mk(3'd2, "ae  ");
                8'hA7:         r = mk(3'd1, "c   ");
                [8'hA8:8'hAB]: r = mk(3'd1, "e   ");
                [8'hAC:8'hAF]: r = mk(3'd1, "i   ");
                8'hB1:         r = mk(3'd1, "n   ");
                [8'hB2:8'hB6], 8'hB8: r = mk(3'd1, "o   ");
                [8'hB9:8'hBC]: r = mk(3'd1, "u   ");
                8'hBD, 8'hBF:  r = mk(3'd1, "y   ");
                default:       r = mk(3'd1, "?   ");
            endcase
        end else if (lead == LEAD_C5) begin
            case (mid)
                8'h92:   r = mk(3'd2, "OE  ");
                8'h93:   r = mk(3'd2, "oe  ");
                default: r = mk(3'd1, "?   ");
            endcase
        end else if (lead == LEAD_E2) begin
            if (mid == 8'h80) begin
                case (last) inside
                    [8'h90:8'h94]: r = mk(3'd1, "-   ");
                    8'h98, 8'h99:  r = mk(3'd1, "'   ");
                    8'h9C, 8'h9D:  r = mk(3'd1, "\"   ");
                    8'hA2:         r = mk(3'd1, "-   ");
                    8'hA6:         r = mk(3'd3, "... ");
                    default:       r = mk(3'd1, "?   ");
                endcase
            end else if (mid == 8'h86) begin
                case (last)
                    8'h90:   r = mk(3'd2, "<-  ");
                    8'h92:   r = mk(3'd2, "->  ");
                    default: r = mk(3'd1, "?   ");
                endcase
            end else if (mid == 8'h9A && last == 8'hA0) begin
                r = mk(3'd1, "!   ");
            end else if (mid == 8'h9C && last == 8'h93) begin
                r = mk(3'd2, "OK  ");
            end
        end
        return r;
    endfunction

endpackage

>>> src/utt_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the pending sequence and the character count of the current string,
// and turns one byte into the characters that it releases.
// ----------------------------------------------------------------------------
module utt_decode import utt_pkg::*; #(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [CFG_W-1:0]  i_cap,
    output t_res              o_res
);

    localparam int CW_W  = $clog2(CAPACITY_MAX);
    localparam int CAP_W = $clog2(CAPACITY_MAX + 1);
    localparam int EW    = (CAP_W > CFG_W) ? CAP_W : CFG_W;
    localparam logic [EW-1:0] CAP_LIM = EW'(CAPACITY_MAX);

    logic [BYTE_W-1:0] r_lead, n_lead;
    logic [BYTE_W-1:0] r_mid,  n_mid;
    logic [1:0]        r_left, n_left;
    logic [CW_W-1:0]   r_cw,   n_cw;

    logic [EW-1:0]    cap_e;
    logic [EW-1:0]    cw_e;
    logic [EW-1:0]    room;
    logic [CNT_W-1:0] room4;
    logic [CNT_W-1:0] n_emit;
    t_str             s;
    logic             emit;

    always_comb begin
        cap_e = EW'(i_cap);
        if (i_cap == '0) begin
            cap_e = EW'(1);
        end else if (cap_e > CAP_LIM) begin
            cap_e = CAP_LIM;
        end
        cw_e  = EW'(r_cw);
        room  = (cw_e + EW'(1) >= cap_e) ? '0 : (cap_e - EW'(1) - cw_e);
        room4 = (room >= EW'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : CNT_W'(room);
    end

    always_comb begin
        n_lead = r_lead;
        n_mid  = r_mid;
        n_left = r_left;
        s      = mk(3'd1, "?   ");
        emit   = 1'b0;
        o_res.ch   = '0;
        o_res.cnt  = '0;
        o_res.last = 1'b0;

        priority if (i_byte == '0) begin
            n_lead = '0;
            n_mid  = '0;
            n_left = '0;
            o_res.last = 1'b1;
            if (r_left != '0 && room4 != '0) begin
                o_res.ch[0] = CHAR_QMARK;
                o_res.ch[1] = CHAR_NUL;
                o_res.cnt   = 3'd2;
            end else begin
                o_res.ch[0] = CHAR_NUL;
                o_res.cnt   = 3'd1;
            end
        end else if (r_left != '0) begin
            n_left = r_left - 2'd1;
            if (r_lead == LEAD_E2 && r_left == 2'd2) begin
                n_mid = i_byte;
            end
            if (r_left == 2'd1) begin
                emit   = 1'b1;
                n_lead = '0;
                n_mid  = '0;
                if (r_lead == LEAD_E2) begin
                    s = lookup(r_lead, r_mid, i_byte);
                end else if (r_lead == LEAD_C2 || r_lead == LEAD_C3
                             || r_lead == LEAD_C5) begin
                    s = lookup(r_lead, i_byte, '0);
                end
            end
        end else if (room4 == '0) begin
            emit = 1'b0;
        end else if (!i_byte[7]) begin
            emit    = 1'b1;
            s.len   = 3'd1;
            s.ch    = '0;
            s.ch[0] = i_byte[CHAR_W-1:0];
        end else if (i_byte == LEAD_C2 || i_byte == LEAD_C3 || i_byte == LEAD_C5) begin
            n_left = 2'd1;
            n_lead = i_byte;
            n_mid  = '0;
        end else if (i_byte[7:3] == 5'b11110) begin
            n_left = 2'd3;
            n_lead = i_byte;
            n_mid  = '0;
        end else if (i_byte[7:4] == 4'b1110) begin
            n_left = 2'd2;
            n_lead = i_byte;
            n_mid  = '0;
        end else if (i_byte[7:5] == 3'b110) begin
            n_left = 2'd1;
            n_lead = i_byte;
            n_mid  = '0;
        end else begin
            emit = 1'b1;
        end

        n_emit = (s.len < room4) ? s.len : room4;
        if (emit) begin
            o_res.ch  = s.ch;
            o_res.cnt = n_emit;
        end

        n_cw = (i_byte == '0) ? '0 : (r_cw + CW_W'(o_res.cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_mid  <= '0;
            r_left <= '0;
            r_cw   <= '0;
        end else if (i_step) begin
            r_lead <= n_lead;
            r_mid  <= n_mid;
            r_left <= n_left;
            r_cw   <= n_cw;
        end
    end

endmodule

>>> src/utf8_to_ascii_transliterator.sv
// ----------------------------------------------------------------------------
// UTF-8 to ASCII transliterator
// An accepted byte is held in the input register and, once the result buffer
// is free, decoded into it, where its first character shows at the port. Throughput: one byte per cycle while
// each byte gives at most one character and the output is not stalled; a byte that expands to more characters
// occupies the result buffer until all of them are taken. Synchronous active-low reset
// clears the sequence state, the buffers and sets the capacity to 512.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator import utt_pkg::*; #(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic                             r_in_valid, n_in_valid;
    logic [BYTE_W-1:0]                r_in_byte;
    logic [CFG_W-1:0]                 r_cap;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] r_ch, n_ch;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic                             r_last, n_last;

    logic buf_free;
    logic move;
    logic in_acc;
    logic out_acc;
    t_res res;

    utt_decode #(
        .CAPACITY_MAX (CAPACITY_MAX)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (move),
        .i_byte  (r_in_byte),
        .i_cap   (r_cap),
        .o_res   (res)
    );

    assign o_out_valid = (r_cnt != '0);
    assign o_out_char  = r_ch[0];
    assign o_out_last  = r_last && (r_cnt == 3'd1);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign buf_free    = (r_cnt == '0) || ((r_cnt == 3'd1) && !i_out_stall);
    assign move        = r_in_valid && buf_free;
    assign o_in_stall  = r_in_valid && !buf_free;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = in_acc ? 1'b1 : (move ? 1'b0 : r_in_valid);
        n_ch   = r_ch;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (move) begin
            n_ch   = res.ch;
            n_cnt  = res.cnt;
            n_last = res.last;
        end else if (out_acc) begin
            n_ch  = r_ch >> CHAR_W;
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_last     <= 1'b0;
            r_cap      <= CAP_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_last     <= n_last;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_byte;
        end
        r_ch <= n_ch;
    end

    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last |-> o_out_char == CHAR_NUL)
        else $error("terminator result carries a non-NUL character");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result buffer count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_in_valid |-> move)
        else $error("held input byte overwritten before decoding");

    a_move_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_cnt > 3'd1 |-> 1'b0)
        else $error("result buffer reloaded while characters remain");

endmodule
